/* hdl/indexed_block_allocator_core_defines.svh */
// assertion macros used by the allocator back end
`ifndef INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH
`define INDEXED_BLOCK_ALLOCATOR_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define IBA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define IBA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/iba_pkg.sv */
// shared constants, status codes and command type of the block allocator
package iba_pkg;

    // sizing
    localparam int NUM_BLOCKS  = 1024;
    localparam int MAX_REQUEST = 64;
    localparam int MAX_FILES   = 128;

    // field widths
    localparam int CFG_W   = 11;
    localparam int FILE_W  = 7;
    localparam int NEED_W  = 7;
    localparam int STAT_W  = 2;
    localparam int BLOCK_W = 10;

    // derived widths
    localparam int PTR_W  = $clog2(NUM_BLOCKS + 1);
    localparam int IDX_W  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int OFF_W  = (MAX_REQUEST > 1) ? $clog2(MAX_REQUEST) : 1;
    localparam int CMP_A  = (CFG_W > PTR_W) ? CFG_W : PTR_W;
    localparam int CMP_W  = (CMP_A > NEED_W) ? CMP_A : NEED_W;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STAT_W-1:0] ST_FAIL = 2'd2;

    // classified request handed from front to back
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [IDX_W-1:0]  base;
        logic [NEED_W-1:0] count;
        logic [FILE_W-1:0] owner;
    } cmd_t;

    // queue write side
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } push_t;

    // queue read side
    typedef struct packed {
        logic not_empty;
        cmd_t cmd;
    } head_t;

endpackage

/* hdl/iba_if.sv */
// request, result and configuration channels of the block allocator

// request channel
interface iba_req_if;
    logic                      valid;
    logic                      ready;
    logic [iba_pkg::FILE_W-1:0] file_id;
    logic [iba_pkg::NEED_W-1:0] need;
    modport source (output valid, output file_id, output need, input ready);
    modport sink (input valid, input file_id, input need, output ready);
endinterface

// result channel
interface iba_res_if;
    logic                        valid;
    logic                        ready;
    logic [iba_pkg::STAT_W-1:0]  status;
    logic [iba_pkg::BLOCK_W-1:0] block_index;
    logic [iba_pkg::FILE_W-1:0]  owner_id;
    logic                        last;
    modport source (output valid, output status, output block_index, output owner_id,
                    output last, input ready);
    modport sink (input valid, input status, input block_index, input owner_id,
                  input last, output ready);
endinterface

// configuration write channel
interface iba_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [iba_pkg::CFG_W-1:0] total_blocks;
    modport source (output valid, output total_blocks, input ready);
    modport sink (input valid, input total_blocks, output ready);
endinterface

/* hdl/iba_front.sv */
// front end: holds the disk size and fill pointer, classifies requests
module iba_front (
    input  logic               clk,
    input  logic               rst_n,
    iba_cfg_if.sink            cfg,
    iba_req_if.sink            req,
    input  logic               q_full,
    output iba_pkg::push_t     wr
);

    logic [iba_pkg::CFG_W-1:0] total_reg;
    logic [iba_pkg::PTR_W-1:0] next_ptr_reg;
    logic [iba_pkg::PTR_W-1:0] next_ptr_next;
    logic [iba_pkg::PTR_W-1:0] disk_size;
    logic [iba_pkg::PTR_W-1:0] avail;
    logic                      too_big;
    logic                      req_beat;
    iba_pkg::cmd_t             cmd;

    // config is always taken; requests while the queue has room
    assign cfg.ready = 1'b1;
    assign req.ready = !q_full;
    assign req_beat  = req.valid && req.ready;

    // disk in use is the register clamped to the store depth
    always_comb
    begin
        if (iba_pkg::CMP_W'(total_reg) > iba_pkg::CMP_W'(iba_pkg::NUM_BLOCKS))
            disk_size = iba_pkg::PTR_W'(iba_pkg::NUM_BLOCKS);
        else
            disk_size = iba_pkg::PTR_W'(total_reg);
    end

    // used blocks always form a prefix, so free space is size minus pointer
    assign avail   = disk_size - next_ptr_reg;
    assign too_big = (iba_pkg::CMP_W'(req.need) > iba_pkg::CMP_W'(iba_pkg::MAX_REQUEST)) ||
                     (iba_pkg::CMP_W'(req.need) > iba_pkg::CMP_W'(avail));

    // classify the request beat
    always_comb
    begin
        cmd.owner     = req.file_id;
        cmd.count     = req.need;
        cmd.base      = iba_pkg::IDX_W'(next_ptr_reg);
        next_ptr_next = next_ptr_reg;
        if (req.need == '0)
            cmd.status = iba_pkg::ST_ZERO;
        else if (too_big)
            cmd.status = iba_pkg::ST_FAIL;
        else
        begin
            cmd.status    = iba_pkg::ST_OK;
            next_ptr_next = next_ptr_reg + iba_pkg::PTR_W'(req.need);
        end
    end

    assign wr.push = req_beat;
    assign wr.cmd  = cmd;

    // disk size register and fill pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= iba_pkg::CFG_W'(1024);
            next_ptr_reg <= '0;
        end
        else if (cfg.valid)
        begin
            total_reg    <= cfg.total_blocks;
            next_ptr_reg <= '0;
        end
        else if (req_beat)
        begin
            next_ptr_reg <= next_ptr_next;
        end
    end

endmodule

/* hdl/iba_queue.sv */
// two-entry command queue between front and back
module iba_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  iba_pkg::push_t wr,
    input  logic           pop,
    output logic           full,
    output iba_pkg::head_t head
);

    iba_pkg::cmd_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full           = (cnt_reg == 2'd2);
    assign head.not_empty = (cnt_reg != 2'd0);
    assign head.cmd       = mem_reg[rd_ptr_reg];
    assign do_push        = wr.push && !full;
    assign do_pop         = pop && head.not_empty;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr.cmd;
    end

    // pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

/* hdl/iba_back.sv */
// back end: expands one command into its result beats
`include "indexed_block_allocator_core_defines.svh"

module iba_back (
    input  logic           clk,
    input  logic           rst_n,
    input  iba_pkg::head_t head,
    output logic           pop,
    iba_res_if.source      res
);

    iba_pkg::cmd_t               cmd_reg;
    logic                        active_reg;
    logic [iba_pkg::OFF_W-1:0]   offset_reg;
    logic                        res_valid_reg;
    logic [iba_pkg::STAT_W-1:0]  status_reg;
    logic [iba_pkg::BLOCK_W-1:0] block_reg;
    logic [iba_pkg::FILE_W-1:0]  owner_reg;
    logic                        last_reg;
    logic                        out_free;
    logic                        emit;
    logic                        is_last;
    logic [iba_pkg::IDX_W-1:0]   cur_block;

    assign out_free  = !res_valid_reg || res.ready;
    assign emit      = active_reg && out_free;
    assign pop       = !active_reg && head.not_empty;
    assign cur_block = cmd_reg.base + iba_pkg::IDX_W'(offset_reg);
    assign is_last   = (cmd_reg.status != iba_pkg::ST_OK) ||
                       (iba_pkg::NEED_W'(offset_reg) + iba_pkg::NEED_W'(1) == cmd_reg.count);

    // command load and beat counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            offset_reg <= '0;
        end
        else if (pop)
        begin
            active_reg <= 1'b1;
            offset_reg <= '0;
        end
        else if (emit)
        begin
            if (is_last)
                active_reg <= 1'b0;
            else
                offset_reg <= offset_reg + iba_pkg::OFF_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= head.cmd;
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (out_free)
            res_valid_reg <= emit;
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            status_reg <= cmd_reg.status;
            block_reg  <= (cmd_reg.status == iba_pkg::ST_OK) ?
                          iba_pkg::BLOCK_W'(cur_block) : '0;
            owner_reg  <= cmd_reg.owner;
            last_reg   <= is_last;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.status      = status_reg;
    assign res.block_index = block_reg;
    assign res.owner_id    = owner_reg;
    assign res.last        = last_reg;

    // checks
    `IBA_ASSERT_NOW(a_fail_is_single, res_valid_reg && (status_reg != iba_pkg::ST_OK), last_reg, "non-ok result without last")
    `IBA_ASSERT_NOW(a_pop_when_idle, pop, !active_reg, "command loaded while expanding another")
    `IBA_ASSERT_NEXT(a_hold_on_stall, active_reg && !out_free && !pop, $stable(offset_reg) && active_reg, "beat counter moved under stall")

endmodule

/* hdl/indexed_block_allocator_core.sv */
// top level of the first-fit block allocator
// Each request beat names a file and a block count; the block answers with one result
// beat per allocated block (lowest free block numbers first, last set on the final one),
// or with a single beat of status zero-size or not-enough-blocks. Blocks are never
// released, so the used blocks always form a prefix of the disk and a fill pointer
// replaces the free map: there is no clearing pass after reset or after a write of
// total_blocks, which frees the whole disk at once. The back end loads a command, then
// sends one result beat per cycle unless the result channel stalls; the front end takes
// a request beat every cycle while the two-entry command queue has room, so the
// sustained rate is set by the result beat loop.
module indexed_block_allocator_core (
    input  logic      clk,
    input  logic      rst_n,
    iba_cfg_if.sink   cfg,
    iba_req_if.sink   req,
    iba_res_if.source res
);

    iba_pkg::push_t wr;
    iba_pkg::head_t head;
    logic           q_full;
    logic           pop;

    // request classification and fill pointer
    iba_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .req    (req),
        .q_full (q_full),
        .wr     (wr)
    );

    // command queue
    iba_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (wr),
        .pop   (pop),
        .full  (q_full),
        .head  (head)
    );

    // result expansion
    iba_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .res   (res)
    );

endmodule

/* bench/tb_indexed_block_allocator_core.sv */
// self-checking testbench of the first-fit block allocator core
module tb_indexed_block_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT     = 38;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 2 * (iba_pkg::MAX_REQUEST + 1);
    localparam int RANDOM_ITEMS = 230;
    localparam int NEED_TOP     = (1 << iba_pkg::NEED_W) - 1;
    localparam int FILE_TOP     = (1 << iba_pkg::FILE_W) - 1;
    localparam int CFG_TOP      = (1 << iba_pkg::CFG_W) - 1;
    localparam logic [iba_pkg::CFG_W-1:0] RESET_TOTAL = iba_pkg::CFG_W'(1024);

    // one request beat
    typedef struct packed {
        logic [iba_pkg::FILE_W-1:0] file_id;
        logic [iba_pkg::NEED_W-1:0] need;
    } alloc_req_t;

    // one result beat
    typedef struct packed {
        logic [iba_pkg::STAT_W-1:0]  status;
        logic [iba_pkg::BLOCK_W-1:0] block_index;
        logic [iba_pkg::FILE_W-1:0]  owner_id;
        logic                        last;
    } alloc_beat_t;

    logic clk;
    logic rst_n;

    iba_cfg_if cfg ();
    iba_req_if req ();
    iba_res_if res ();

    indexed_block_allocator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req),
        .res   (res)
    );

    alloc_req_t                requests_queued[$];
    alloc_beat_t               grants_due[$];
    bit                        block_free[iba_pkg::NUM_BLOCKS];
    int unsigned               free_left;
    logic [iba_pkg::CFG_W-1:0] disk_total;
    int unsigned               mismatches;
    int unsigned               requests_made;
    int unsigned               requests_taken;
    int unsigned               quiet_cycles;
    bit                        no_gaps;
    bit                        req_beat;
    bit                        cfg_beat;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // blocks usable on the current disk, clamped to the map size
    function automatic int unsigned disk_blocks();
        return (disk_total > iba_pkg::NUM_BLOCKS) ? iba_pkg::NUM_BLOCKS : int'(disk_total);
    endfunction

    // a total_blocks write frees the whole disk
    function automatic void reload_disk(input logic [iba_pkg::CFG_W-1:0] total);
        disk_total = total;
        foreach (block_free[b])
            block_free[b] = 1'b1;
        free_left = disk_blocks();
    endfunction

    // first-fit allocation of one request, queuing the result beats it causes
    function automatic void allocate_blocks(input alloc_req_t rq);
        alloc_beat_t beat;
        int unsigned granted;
        granted          = 0;
        beat.owner_id    = rq.file_id;
        beat.block_index = '0;
        beat.last        = 1'b1;
        if (rq.need == 0)
        begin
            beat.status = iba_pkg::ST_ZERO;
            grants_due.push_back(beat);
        end
        else if (rq.need > iba_pkg::MAX_REQUEST || free_left < rq.need)
        begin
            beat.status = iba_pkg::ST_FAIL;
            grants_due.push_back(beat);
        end
        else
        begin
            beat.status = iba_pkg::ST_OK;
            for (int b = 0; b < disk_blocks() && granted < rq.need; b++)
            begin
                if (block_free[b])
                begin
                    block_free[b]    = 1'b0;
                    granted++;
                    beat.block_index = iba_pkg::BLOCK_W'(b);
                    beat.last        = (granted == rq.need);
                    grants_due.push_back(beat);
                end
            end
            free_left -= granted;
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_request(input logic [iba_pkg::FILE_W-1:0] file_id,
                                 input logic [iba_pkg::NEED_W-1:0] need);
        alloc_req_t rq;
        rq.file_id = file_id;
        rq.need    = need;
        requests_queued.push_back(rq);
        requests_made++;
    endtask

    // wait until every request is taken and every result beat has come
    task automatic settle();
        while (requests_taken != requests_made || grants_due.size() != 0)
            @(negedge clk);
    endtask

    // one configuration beat, sent while the block is idle
    task automatic write_total(input logic [iba_pkg::CFG_W-1:0] total);
        @(negedge clk);
        cfg.valid        <= 1'b1;
        cfg.total_blocks <= total;
        do
            @(negedge clk);
        while (!cfg_beat);
        cfg.valid <= 1'b0;
    endtask

    // request driver and result backpressure
    always @(negedge clk)
    begin
        alloc_req_t nxt;
        res.ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
        if (!req.valid || req_beat)
        begin
            if (rst_n && requests_queued.size() != 0
                && (no_gaps || $urandom_range(99) >= IDLE_PCT))
            begin
                nxt = requests_queued.pop_front();
                req.valid   <= 1'b1;
                req.file_id <= nxt.file_id;
                req.need    <= nxt.need;
            end
            else
            begin
                req.valid <= 1'b0;
            end
        end
    end

    // monitor: predict on accepted requests, check result beats, watchdog
    always @(posedge clk)
    begin
        alloc_req_t  taken;
        alloc_beat_t seen;
        alloc_beat_t want;
        if (rst_n)
        begin
            req_beat <= req.valid && req.ready;
            cfg_beat <= cfg.valid && cfg.ready;

            if (cfg.valid && cfg.ready)
                reload_disk(cfg.total_blocks);

            if (req.valid && req.ready)
            begin
                taken.file_id = req.file_id;
                taken.need    = req.need;
                allocate_blocks(taken);
                requests_taken++;
            end

            // compare each result beat with the oldest expected one
            if (res.valid && res.ready)
            begin
                seen.status      = res.status;
                seen.block_index = res.block_index;
                seen.owner_id    = res.owner_id;
                seen.last        = res.last;
                if (grants_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected beat status %0d block %0d owner %0d",
                                              seen.status, seen.block_index, seen.owner_id));
                end
                else
                begin
                    want = grants_due.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d (owner %0d)",
                                                  seen.status, want.status, want.owner_id));
                    if (seen.block_index !== want.block_index)
                        report_mismatch($sformatf("block_index %0d, expected %0d",
                                                  seen.block_index, want.block_index));
                    if (seen.owner_id !== want.owner_id)
                        report_mismatch($sformatf("owner_id %0d, expected %0d",
                                                  seen.owner_id, want.owner_id));
                    if (seen.last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b (block %0d)",
                                                  seen.last, want.last, want.block_index));
                end
            end

            // watchdog on cycles with no beat on any channel
            if ((req.valid && req.ready) || (res.valid && res.ready)
                || (cfg.valid && cfg.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("FAIL indexed_block_allocator_core");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned                drawn;
        int unsigned                phase;
        int unsigned                span;
        int unsigned                roll;
        logic [iba_pkg::CFG_W-1:0]  total;
        logic [iba_pkg::NEED_W-1:0] need;
        logic [iba_pkg::FILE_W-1:0] owner;

        rst_n            = 1'b0;
        no_gaps          = 1'b0;
        req_beat         = 1'b0;
        cfg_beat         = 1'b0;
        mismatches       = 0;
        requests_made    = 0;
        requests_taken   = 0;
        quiet_cycles     = 0;
        req.valid        = 1'b0;
        req.file_id      = '0;
        req.need         = '0;
        res.ready        = 1'b0;
        cfg.valid        = 1'b0;
        cfg.total_blocks = '0;
        reload_disk(RESET_TOTAL);

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // reset disk: zero-size, single block, largest legal and oversize requests
        queue_request(0, 0);
        queue_request(iba_pkg::FILE_W'(FILE_TOP), 0);
        queue_request(0, 1);
        queue_request(iba_pkg::FILE_W'(FILE_TOP), iba_pkg::NEED_W'(iba_pkg::MAX_REQUEST));
        queue_request(42, iba_pkg::NEED_W'(iba_pkg::MAX_REQUEST + 1));
        queue_request(85, iba_pkg::NEED_W'(NEED_TOP));
        queue_request(1, 3);
        settle();

        // empty disk: every nonzero request fails
        write_total('0);
        queue_request(3, 1);
        queue_request(4, 0);
        queue_request(9, iba_pkg::NEED_W'(iba_pkg::MAX_REQUEST));
        settle();

        // one-block disk
        write_total(1);
        queue_request(10, 1);
        queue_request(11, 1);
        queue_request(12, 0);
        settle();

        // small disk filled exactly, then short of blocks
        write_total(5);
        queue_request(20, 3);
        queue_request(21, 3);
        queue_request(22, 2);
        queue_request(23, 1);
        settle();

        // total above the map size is clamped
        write_total(iba_pkg::CFG_W'(CFG_TOP));
        queue_request(30, iba_pkg::NEED_W'(iba_pkg::MAX_REQUEST));
        queue_request(31, iba_pkg::NEED_W'(iba_pkg::MAX_REQUEST));
        settle();

        // random phases, each on a fresh disk size
        drawn = 0;
        phase = 0;
        while (drawn < RANDOM_ITEMS)
        begin
            case ($urandom_range(5))
                0:       total = RESET_TOTAL;
                1:       total = iba_pkg::CFG_W'(CFG_TOP);
                2:       total = iba_pkg::CFG_W'($urandom_range(1, iba_pkg::MAX_REQUEST));
                3:       total = iba_pkg::CFG_W'($urandom_range(iba_pkg::MAX_REQUEST + 1,
                                                                iba_pkg::NUM_BLOCKS - 1));
                4:       total = iba_pkg::CFG_W'($urandom_range(0, CFG_TOP));
                default: total = 1;
            endcase
            write_total(total);
            no_gaps = (phase == 2);
            span    = $urandom_range(20, 50);
            repeat (span)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                    need = 0;
                else if (roll < 20)
                    need = iba_pkg::NEED_W'($urandom_range(iba_pkg::MAX_REQUEST + 1, NEED_TOP));
                else if (roll < 45)
                    need = iba_pkg::NEED_W'($urandom_range(1, 8));
                else
                    need = iba_pkg::NEED_W'($urandom_range(1, iba_pkg::MAX_REQUEST));
                owner = iba_pkg::FILE_W'($urandom_range(0, FILE_TOP));
                queue_request(owner, need);
            end
            drawn += span;
            phase++;
            settle();
            no_gaps = 1'b0;
        end

        // drain: catch any stray result beats
        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0 && grants_due.size() == 0)
            $display("PASS indexed_block_allocator_core");
        else
            $display("FAIL indexed_block_allocator_core");
        $finish;
    end

endmodule
